### rtl/plob_pkg.sv
// Shared types and constants for the price-level order book.
// No dependencies; every other file of the block imports this package.
package plob_pkg;

   localparam int PRICE_W = 32;
   localparam int QTY_W = 32;
   localparam int MID_W = 33;
   localparam int MODE_W = 2;
   localparam int DEPTH_W = 5;
   localparam int DEFAULT_BOOK_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_UPDATE   = 2'd0,
      MODE_CLEAR    = 2'd1,
      MODE_SNAPSHOT = 2'd2,
      MODE_LIST     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUT,
      OP_DROP,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } level_type;

   typedef struct packed {
      cell_op_type        op;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cell_cmd_type;

endpackage

### rtl/plob_if.sv
// Valid/ready channel interfaces for the order book request and response transactions.
// Depends on plob_pkg for the field widths.
interface plob_req_if
   import plob_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic               book_side;
   logic [PRICE_W-1:0] level_price;
   logic [QTY_W-1:0]   level_qty;

   modport source (output valid, mode, book_side, level_price, level_qty, input ready);
   modport sink (input valid, mode, book_side, level_price, level_qty, output ready);
endinterface

interface plob_rsp_if
   import plob_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               bid_present;
   logic [PRICE_W-1:0] top_bid_price;
   logic [QTY_W-1:0]   top_bid_qty;
   logic               ask_present;
   logic [PRICE_W-1:0] top_ask_price;
   logic [QTY_W-1:0]   top_ask_qty;
   logic [MID_W-1:0]   mid_half_ticks;
   logic               book_empty;
   logic [PRICE_W-1:0] listed_price;
   logic [QTY_W-1:0]   listed_qty;
   logic               run_last;

   modport source (output valid, accepted, bid_present, top_bid_price, top_bid_qty,
                   ask_present, top_ask_price, top_ask_qty, mid_half_ticks, book_empty,
                   listed_price, listed_qty, run_last, input ready);
   modport sink (input valid, accepted, bid_present, top_bid_price, top_bid_qty,
                 ask_present, top_ask_price, top_ask_qty, mid_half_ticks, book_empty,
                 listed_price, listed_qty, run_last, output ready);
endinterface

### rtl/plob_cell.sv
// One price-level cell of a sorted side chain.
// Depends on plob_pkg for the level and command types.
module plob_cell
   import plob_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         asc,
   input  cell_cmd_type cmd,
   input  logic         found,
   input  logic         keep,
   input  logic         up_better,
   input  level_type    up_level,
   input  level_type    down_level,
   output logic         better,
   output logic         eq,
   output level_type    level
);

   level_type lvl_ff;
   level_type lvl_in;

   // An empty cell counts as worse than any incoming price.
   assign better = !lvl_ff.valid ||
                   (asc ? (cmd.price < lvl_ff.price) : (cmd.price > lvl_ff.price));
   assign eq = lvl_ff.valid && (cmd.price == lvl_ff.price);
   assign level = lvl_ff;

   always_comb begin
      lvl_in = lvl_ff;
      case (cmd.op)
         OP_PUT: begin
            if (found) begin
               if (eq) lvl_in.qty = cmd.qty;
            end else if (better) begin
               if (up_better) begin
                  lvl_in = up_level;
               end else begin
                  lvl_in.valid = 1'b1;
                  lvl_in.price = cmd.price;
                  lvl_in.qty = cmd.qty;
               end
            end
         end
         OP_DROP: begin
            if (found && (better || eq)) lvl_in = down_level;
         end
         OP_CLEAR: lvl_in.valid = 1'b0;
         default: ;
      endcase
      if (!keep) lvl_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff.valid <= 1'b0;
      end else begin
         lvl_ff <= lvl_in;
      end
   end

endmodule

### rtl/plob_side.sv
// One side of the book: a sorted chain of price-level cells with depth trimming.
// Depends on plob_pkg and plob_cell.
module plob_side
   import plob_pkg::*;
#(
   parameter int DEPTH = DEFAULT_BOOK_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         asc,
   input  cell_cmd_type cmd,
   input  logic         trim_en,
   input  logic [DEPTH_W-1:0] depth,
   output level_type    levels [DEPTH]
);

   localparam int CMP_W = 7;

   logic [DEPTH-1:0] better_vec;
   logic [DEPTH-1:0] eq_vec;
   logic             found;

   assign found = |eq_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
      logic      keep;
      logic      up_better;
      level_type up_level;
      level_type down_level;

      // Cell zero always survives trimming, so a depth of zero acts as one.
      assign keep = !trim_en || (i == 0) || (CELL_IDX < CMP_W'(depth));

      if (i == 0) begin : g_head
         assign up_better = 1'b0;
         assign up_level = '0;
      end else begin : g_body
         assign up_better = better_vec[i-1];
         assign up_level = levels[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign down_level = '0;
      end else begin : g_mid
         assign down_level = levels[i+1];
      end

      plob_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .asc        (asc),
         .cmd        (cmd),
         .found      (found),
         .keep       (keep),
         .up_better  (up_better),
         .up_level   (up_level),
         .down_level (down_level),
         .better     (better_vec[i]),
         .eq         (eq_vec[i]),
         .level      (levels[i])
      );
   end

endmodule

### rtl/price_level_order_book.sv
// Top level of the price-level order book: request decode, listing sequencer and response.
// Depends on plob_pkg, plob_if and plob_side.
//
// Usage: requests arrive on req_bus (valid/ready); each transaction carries a mode,
// a side, a price and a quantity. Responses leave on rsp_bus (valid/ready). The depth
// register is written through csr_write_en/csr_write_data; the user must write it only
// while the block is idle, and the block itself does not enforce this. Each side is a
// chain of BOOK_DEPTH cells kept sorted best first; an update, delete, snapshot load or
// clear changes every cell of the chain in the same clock edge that accepts the request,
// and trimming to the depth in use happens in that edge too. The registered response
// appears in the cycle after the request is accepted. An update, clear or snapshot request
// yields one response, so such requests stream at one per cycle while the receiver keeps
// rsp_bus.ready high. A list request yields one response per listed level (at most the
// smaller of 16 and BOOK_DEPTH, one response for an empty side) and occupies the block
// until its final response is taken, as the sequencer walks the cells one per response.
// The top-of-book fields of each response come straight from the cell registers.
// A new request is taken in the cycle the final response of the previous one is
// taken. When the receiver stalls, the response holds and no request is accepted.
// Reset (synchronous, active high) empties both sides and sets the depth to 16.
module price_level_order_book
   import plob_pkg::*;
#(
   parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   plob_req_if.sink           req_bus,
   plob_rsp_if.source         rsp_bus,
   input  logic               csr_write_en,
   input  logic [DEPTH_W-1:0] csr_write_data
);

   localparam int LIST_MAX = (MAX_RESULTS < BOOK_DEPTH) ? MAX_RESULTS : BOOK_DEPTH;
   localparam int IDX_W = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
   localparam int CELL_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int PAD_W = $clog2(BOOK_DEPTH + 1);

   // Response bookkeeping registers.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accepted_ff, accepted_in;
   logic               list_mode_ff, list_mode_in;
   logic               list_side_ff, list_side_in;
   logic [IDX_W-1:0]   list_idx_ff, list_idx_in;
   logic [DEPTH_W-1:0] depth_ff;

   logic         req_fire;
   logic         rsp_fire;
   logic         rsp_last;
   mode_type     req_mode;
   logic         price_ok;
   logic         qty_ok;
   cell_cmd_type bid_cmd, ask_cmd;
   cell_op_type  side_op;
   logic         item_ok;

   level_type bid_levels [BOOK_DEPTH];
   level_type ask_levels [BOOK_DEPTH];

   assign req_mode = mode_type'(req_bus.mode);
   assign price_ok = (req_bus.level_price != '0);
   assign qty_ok = (req_bus.level_qty != '0);

   // A new request waits until the final response of the previous one leaves.
   assign req_bus.ready = !rsp_valid_ff || (rsp_bus.ready && rsp_last);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;

   // Decode the request into one cell command per side. Rejected items still trim.
   always_comb begin
      side_op = OP_NONE;
      item_ok = 1'b1;
      unique case (req_mode)
         MODE_UPDATE: begin
            item_ok = price_ok;
            if (price_ok) side_op = qty_ok ? OP_PUT : OP_DROP;
         end
         MODE_SNAPSHOT: begin
            item_ok = price_ok && qty_ok;
            if (price_ok && qty_ok) side_op = OP_PUT;
         end
         MODE_CLEAR: side_op = OP_CLEAR;
         MODE_LIST: side_op = OP_NONE;
         default: side_op = OP_NONE;
      endcase

      bid_cmd.price = req_bus.level_price;
      bid_cmd.qty = req_bus.level_qty;
      ask_cmd.price = req_bus.level_price;
      ask_cmd.qty = req_bus.level_qty;
      bid_cmd.op = OP_NONE;
      ask_cmd.op = OP_NONE;
      if (req_fire) begin
         if (side_op == OP_CLEAR) begin
            bid_cmd.op = OP_CLEAR;
            ask_cmd.op = OP_CLEAR;
         end else if (req_bus.book_side) begin
            ask_cmd.op = side_op;
         end else begin
            bid_cmd.op = side_op;
         end
      end
   end

   plob_side #(.DEPTH(BOOK_DEPTH)) u_bids (
      .clock   (clock),
      .reset   (reset),
      .asc     (1'b0),
      .cmd     (bid_cmd),
      .trim_en (req_fire),
      .depth   (depth_ff),
      .levels  (bid_levels)
   );

   plob_side #(.DEPTH(BOOK_DEPTH)) u_asks (
      .clock   (clock),
      .reset   (reset),
      .asc     (1'b1),
      .cmd     (ask_cmd),
      .trim_en (req_fire),
      .depth   (depth_ff),
      .levels  (ask_levels)
   );

   // Listing walks the selected chain from its best cell; the run ends at the
   // first empty cell or at the result limit.
   logic [BOOK_DEPTH:0] sel_valid_pad;
   logic [PAD_W-1:0]    next_cell;
   level_type           sel_level;
   logic [CELL_W-1:0]   sel_cell;

   assign sel_cell = CELL_W'(list_idx_ff);
   assign next_cell = PAD_W'(list_idx_ff) + PAD_W'(1);

   always_comb begin
      sel_valid_pad[BOOK_DEPTH] = 1'b0;
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         sel_valid_pad[i] = list_side_ff ? ask_levels[i].valid : bid_levels[i].valid;
      end
   end

   assign sel_level = list_side_ff ? ask_levels[sel_cell] : bid_levels[sel_cell];
   assign rsp_last = !list_mode_ff || (list_idx_ff == IDX_W'(LIST_MAX - 1)) ||
                     !sel_valid_pad[next_cell];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      accepted_in = accepted_ff;
      list_mode_in = list_mode_ff;
      list_side_in = list_side_ff;
      list_idx_in = list_idx_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         accepted_in = item_ok;
         list_mode_in = (req_mode == MODE_LIST);
         list_side_in = req_bus.book_side;
         list_idx_in = '0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            rsp_valid_in = 1'b0;
         end else begin
            list_idx_in = list_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         accepted_ff <= 1'b0;
         list_mode_ff <= 1'b0;
         list_side_ff <= 1'b0;
         list_idx_ff <= '0;
         depth_ff <= DEPTH_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff <= accepted_in;
         list_mode_ff <= list_mode_in;
         list_side_ff <= list_side_in;
         list_idx_ff <= list_idx_in;
         if (csr_write_en) depth_ff <= csr_write_data;
      end
   end

   // The book does not change while a response waits, so the top-of-book fields
   // are taken directly from the head cells of both chains.
   logic bid_here, ask_here;
   assign bid_here = bid_levels[0].valid;
   assign ask_here = ask_levels[0].valid;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.accepted = accepted_ff;
   assign rsp_bus.bid_present = bid_here;
   assign rsp_bus.top_bid_price = bid_here ? bid_levels[0].price : '0;
   assign rsp_bus.top_bid_qty = bid_here ? bid_levels[0].qty : '0;
   assign rsp_bus.ask_present = ask_here;
   assign rsp_bus.top_ask_price = ask_here ? ask_levels[0].price : '0;
   assign rsp_bus.top_ask_qty = ask_here ? ask_levels[0].qty : '0;
   assign rsp_bus.mid_half_ticks = (bid_here && ask_here) ?
      (MID_W'(bid_levels[0].price) + MID_W'(ask_levels[0].price)) : '0;
   assign rsp_bus.book_empty = !bid_here && !ask_here;
   assign rsp_bus.listed_price = (list_mode_ff && sel_level.valid) ? sel_level.price : '0;
   assign rsp_bus.listed_qty = (list_mode_ff && sel_level.valid) ? sel_level.qty : '0;
   assign rsp_bus.run_last = rsp_last;

endmodule
